[design/sis_pkg.sv]
package sis_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 64;
	localparam int TAG_W = 16;
	localparam int PADDR_W = 3;

	localparam logic REG_DESCENDING = 1'b0;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic ins;
		logic drain;
		logic desc;
	} cell_ctrl_t;

endpackage

[design/sis_cell.sv]
module sis_cell
	import sis_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  key_t       new_key,
	input  tag_t       new_tag,
	input  key_t       left_key,
	input  tag_t       left_tag,
	input  key_t       right_key,
	input  tag_t       right_tag,
	input  logic       taken_in,
	output logic       taken_out,
	output key_t       key,
	output tag_t       tag
);

	key_t key_q;
	tag_t tag_q;
	logic ahead;

	// an empty cell always accepts, so the first free cell takes an append
	always_comb begin
		if (!occ) begin
			ahead = 1'b1;
		end else if (ctrl.desc) begin
			ahead = key_q < new_key;
		end else begin
			ahead = new_key < key_q;
		end
	end

	assign taken_out = taken_in | ahead;
	assign key = key_q;
	assign tag = tag_q;

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (ctrl.ins) begin
			if (taken_in) begin
				key_q <= left_key;
				tag_q <= left_tag;
			end else if (ahead) begin
				key_q <= new_key;
				tag_q <= new_tag;
			end
		end
	end

endmodule

[design/stable_insertion_sorter.sv]
// Stable insertion sorter built as a row of CAPACITY cells. A record is
// accepted when start is high and busy is low; each record is compared in
// every cell at once and slots in within the cycle, so records that are not
// marked last are taken one per cycle back to back. After the record marked
// last, busy stays high while the row shifts toward its head cell and
// emits one result per cycle in sorted order, one for each stored entry
// (1 to CAPACITY). A result is on out_key, out_tag, last_out and overflow
// for exactly one cycle with out_valid high; the receiver cannot stall it,
// so it must take every strobed transaction. Records arriving with the
// store full are dropped and overflow is set on every result of that run.
// The sort direction register answers at addresses 0 to 3.
module stable_insertion_sorter
	import sis_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [63:0] sort_key,
	input  logic               key_is_integer,
	input  logic [15:0]        record_tag,
	input  logic               last_item,
	output logic               out_valid,
	output logic signed [63:0] out_key,
	output logic [15:0]        out_tag,
	output logic               last_out,
	output logic               overflow,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic       desc_q;
	logic       drain_q;
	logic       dropped_q;
	cnt_t       count_q;
	logic       out_valid_q;
	key_t       out_key_q;
	tag_t       out_tag_q;
	logic       last_out_q;
	logic       overflow_q;

	logic       accept;
	logic       full;
	key_t       eff_key;
	cell_ctrl_t ctrl;

	logic [CAPACITY-1:0] occ;
	logic [CAPACITY:0]   taken;
	key_t                cell_key [CAPACITY];
	tag_t                cell_tag [CAPACITY];

	assign accept = start & ~drain_q;
	assign full = count_q == cnt_t'(CAPACITY);
	assign eff_key = key_is_integer ? sort_key : '0;
	assign busy = drain_q;

	assign ctrl.ins = accept & ~full;
	assign ctrl.drain = drain_q;
	assign ctrl.desc = desc_q;

	assign taken[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		key_t left_key;
		tag_t left_tag;
		key_t right_key;
		tag_t right_tag;

		assign occ[i] = count_q > cnt_t'(i);

		if (i == 0) begin : g_head
			assign left_key = eff_key;
			assign left_tag = record_tag;
		end else begin : g_mid
			assign left_key = cell_key[i-1];
			assign left_tag = cell_tag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_key = '0;
			assign right_tag = '0;
		end else begin : g_body
			assign right_key = cell_key[i+1];
			assign right_tag = cell_tag[i+1];
		end

		sis_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ[i]),
			.new_key   (eff_key),
			.new_tag   (record_tag),
			.left_key  (left_key),
			.left_tag  (left_tag),
			.right_key (right_key),
			.right_tag (right_tag),
			.taken_in  (taken[i]),
			.taken_out (taken[i+1]),
			.key       (cell_key[i]),
			.tag       (cell_tag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			dropped_q <= 1'b0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= drain_q;
			if (drain_q) begin
				count_q <= count_q - cnt_t'(1);
				if (count_q == cnt_t'(1)) begin
					drain_q <= 1'b0;
					dropped_q <= 1'b0;
				end
			end else if (accept) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + cnt_t'(1);
				end
				if (last_item) begin
					drain_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_q) begin
			out_key_q <= cell_key[0];
			out_tag_q <= cell_tag[0];
			last_out_q <= count_q == cnt_t'(1);
			overflow_q <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_key = out_key_q;
	assign out_tag = out_tag_q;
	assign last_out = last_out_q;
	assign overflow = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_DESCENDING) begin
			desc_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_DESCENDING) ? {31'b0, desc_q} : '0;

endmodule
